// ===== rtl/grid_net_bbox_cost_assert.svh =====
// assertion macros used by the grid net bounding box cost design
`ifndef GRID_NET_BBOX_COST_ASSERT_SVH
`define GRID_NET_BBOX_COST_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define GNBC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define GNBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gnbc_pkg.sv =====
// package with sizes and types for the grid net bounding box cost design
`timescale 1ns / 1ps

package gnbc_pkg;

    // grid limits
    localparam int MAX_PARTS   = 512;
    localparam int MAX_COLUMNS = 64;

    // field widths
    localparam int COUNT_W = 16;
    localparam int COL_W   = 7;
    localparam int COST_W  = 11;

    // derived widths
    localparam int CNT_W  = $clog2(MAX_PARTS + 1);
    localparam int ROW_W  = $clog2(MAX_PARTS + 2);
    localparam int PROD_W = ROW_W + COL_W;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // final net state handed from the tracker to the cost stage
    typedef struct packed {
        logic [CNT_W-1:0] occupied;
        logic [ROW_W-1:0] min_row;
        logic [ROW_W-1:0] max_row;
        logic [COL_W-1:0] min_col;
        logic [COL_W-1:0] max_col;
        logic             err;
    } t_snap;

endpackage

// ===== rtl/grid_net_bbox_cost.sv =====
// top level of the grid net bounding box cost block
//
//   channel  direction  handshake                payload
//   input    in         i_valid / o_stall        i_part_count, i_last
//   result   out        o_valid / i_stall        o_cost, o_error
//   config   in         i_cfg_valid / o_cfg_ready  i_cfg_data (columns per row)
//
// one cell is taken every cycle while o_stall is low; o_valid rises once a taken last cell has passed
// the stages (input register, net tracker with snapshot register, cost multiply to result register)
// synchronous active-low reset clears all net state and sets columns per row to 4
// a stalled result only holds back the input once the snapshot register is also full
// and a last cell is waiting; ordinary cells keep flowing
`timescale 1ns / 1ps

module grid_net_bbox_cost (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [gnbc_pkg::COUNT_W-1:0]  i_part_count,
    input  logic                          i_last,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [gnbc_pkg::COST_W-1:0]   o_cost,
    output logic                          o_error,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gnbc_pkg::COL_W-1:0]    i_cfg_data
);

    logic                         r_in_valid;
    logic [gnbc_pkg::COUNT_W-1:0] r_in_count;
    logic                         r_in_last;
    logic [gnbc_pkg::COL_W-1:0]   r_cols;
    logic [gnbc_pkg::COL_W-1:0]   width;
    gnbc_pkg::t_snap              snap;
    logic                         snap_valid;
    logic                         cost_valid;
    logic                         out_free;
    logic                         snap_take;
    logic                         in_adv;
    logic                         in_free;

    // pipeline flow control
    assign out_free  = !cost_valid || !i_stall;
    assign snap_take = snap_valid && out_free;
    assign in_adv    = r_in_valid && (!r_in_last || !snap_valid || out_free);
    assign in_free   = !r_in_valid || in_adv;
    assign o_stall   = !in_free;

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= gnbc_pkg::COL_W'(4);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cols <= i_cfg_data;
        end
    end

    // row width clamped to the supported range
    always_comb begin
        if (r_cols == '0) begin
            width = gnbc_pkg::COL_W'(1);
        end else if (r_cols > gnbc_pkg::COL_W'(gnbc_pkg::MAX_COLUMNS)) begin
            width = gnbc_pkg::COL_W'(gnbc_pkg::MAX_COLUMNS);
        end else begin
            width = r_cols;
        end
    end

    // input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_valid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (in_free && i_valid) begin
            r_in_count <= i_part_count;
            r_in_last  <= i_last;
        end
    end

    gnbc_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (in_adv),
        .i_part_count (r_in_count),
        .i_last       (r_in_last),
        .i_width      (width),
        .i_snap_take  (snap_take),
        .o_snap       (snap),
        .o_snap_valid (snap_valid)
    );

    gnbc_cost u_cost (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (snap_take),
        .i_snap  (snap),
        .i_stall (i_stall),
        .o_valid (cost_valid),
        .o_cost  (o_cost),
        .o_error (o_error)
    );

    assign o_valid = cost_valid;

endmodule

// ===== rtl/gnbc_accum.sv =====
// per-cell position tracking, range and count update, net snapshot register
`timescale 1ns / 1ps
`include "grid_net_bbox_cost_assert.svh"

module gnbc_accum (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic [gnbc_pkg::COUNT_W-1:0]  i_part_count,
    input  logic                          i_last,
    input  logic [gnbc_pkg::COL_W-1:0]    i_width,
    input  logic                          i_snap_take,
    output gnbc_pkg::t_snap               o_snap,
    output logic                          o_snap_valid
);

    logic [gnbc_pkg::COL_W-1:0] r_col, n_col;
    logic [gnbc_pkg::ROW_W-1:0] r_row, n_row;
    logic [gnbc_pkg::ROW_W-1:0] r_min_row, n_min_row;
    logic [gnbc_pkg::ROW_W-1:0] r_max_row, n_max_row;
    logic [gnbc_pkg::COL_W-1:0] r_min_col, n_min_col;
    logic [gnbc_pkg::COL_W-1:0] r_max_col, n_max_col;
    logic [gnbc_pkg::CNT_W-1:0] r_occ, n_occ;
    logic [gnbc_pkg::CNT_W-1:0] r_cells, n_cells;
    logic                       r_err, n_err;
    gnbc_pkg::t_snap            r_snap;
    logic                       r_snap_valid;

    logic negative;
    logic positive;
    logic overflow;

    // cell classification
    assign negative = i_part_count[gnbc_pkg::COUNT_W-1];
    assign positive = !negative && (i_part_count != '0);
    assign overflow = r_cells >= gnbc_pkg::CNT_W'(gnbc_pkg::MAX_PARTS);

    // next state after this cell
    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_min_row = r_min_row;
        n_max_row = r_max_row;
        n_min_col = r_min_col;
        n_max_col = r_max_col;
        n_occ     = r_occ;
        n_cells   = r_cells;
        n_err     = r_err;
        if (overflow) begin
            n_err = 1'b1;
        end else begin
            if (negative) begin
                n_err = 1'b1;
            end
            if (positive) begin
                n_occ = r_occ + 1'b1;
                if (r_row < r_min_row) n_min_row = r_row;
                if (r_row > r_max_row) n_max_row = r_row;
                if (r_col < r_min_col) n_min_col = r_col;
                if (r_col > r_max_col) n_max_col = r_col;
            end
            n_cells = r_cells + 1'b1;
            // wrap to the next row at the row width, also when already past it
            if (r_col >= i_width) begin
                n_col = gnbc_pkg::COL_W'(1);
                n_row = r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    // net state, cleared after the last cell of a net
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_adv && i_last)) begin
            r_col     <= gnbc_pkg::COL_W'(1);
            r_row     <= gnbc_pkg::ROW_W'(1);
            r_min_row <= '1;
            r_max_row <= '0;
            r_min_col <= '1;
            r_max_col <= '0;
            r_occ     <= '0;
            r_cells   <= '0;
            r_err     <= 1'b0;
        end else if (i_adv) begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_min_row <= n_min_row;
            r_max_row <= n_max_row;
            r_min_col <= n_min_col;
            r_max_col <= n_max_col;
            r_occ     <= n_occ;
            r_cells   <= n_cells;
            r_err     <= n_err;
        end
    end

    // snapshot valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (i_adv && i_last) begin
            r_snap_valid <= 1'b1;
        end else if (i_snap_take) begin
            r_snap_valid <= 1'b0;
        end
    end

    // snapshot payload of the finished net
    always_ff @(posedge i_clk) begin
        if (i_adv && i_last) begin
            r_snap.occupied <= n_occ;
            r_snap.min_row  <= n_min_row;
            r_snap.max_row  <= n_max_row;
            r_snap.min_col  <= n_min_col;
            r_snap.max_col  <= n_max_col;
            r_snap.err      <= n_err;
        end
    end

    assign o_snap       = r_snap;
    assign o_snap_valid = r_snap_valid;

    // checks on the tracked net state
    `GNBC_ASSERT_NOW(a_cells_bound, 1'b1,
        r_cells <= gnbc_pkg::CNT_W'(gnbc_pkg::MAX_PARTS), "cell count beyond grid store")
    `GNBC_ASSERT_NOW(a_occ_le_cells, 1'b1, r_occ <= r_cells,
        "occupied count exceeds cells seen")
    `GNBC_ASSERT_NOW(a_range_order, r_occ != '0,
        (r_min_row <= r_max_row) && (r_min_col <= r_max_col), "bounding box range inverted")
    `GNBC_ASSERT_NEXT(a_last_clears, i_adv && i_last,
        r_snap_valid && (r_cells == '0) && (r_occ == '0), "net not closed after last cell")

endmodule

// ===== rtl/gnbc_cost.sv =====
// bounding box area, occupied count add, saturation and result register
`timescale 1ns / 1ps

module gnbc_cost (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_load,
    input  gnbc_pkg::t_snap              i_snap,
    input  logic                         i_stall,
    output logic                         o_valid,
    output logic [gnbc_pkg::COST_W-1:0]  o_cost,
    output logic                         o_error
);

    logic [gnbc_pkg::ROW_W-1:0]  rows;
    logic [gnbc_pkg::COL_W-1:0]  cols;
    logic [gnbc_pkg::PROD_W-1:0] area;
    logic [gnbc_pkg::SUM_W-1:0]  total;
    logic [gnbc_pkg::COST_W-1:0] n_cost;
    logic                        r_valid;
    logic [gnbc_pkg::COST_W-1:0] r_cost;
    logic                        r_error;

    // spans and area
    assign rows  = i_snap.max_row - i_snap.min_row + 1'b1;
    assign cols  = i_snap.max_col - i_snap.min_col + 1'b1;
    assign area  = gnbc_pkg::PROD_W'(rows) * gnbc_pkg::PROD_W'(cols);
    assign total = gnbc_pkg::SUM_W'(area) + gnbc_pkg::SUM_W'(i_snap.occupied);

    // empty net gives zero, large cost saturates
    always_comb begin
        if (i_snap.occupied == '0) begin
            n_cost = '0;
        end else if (total > gnbc_pkg::SUM_W'(gnbc_pkg::COST_MAX)) begin
            n_cost = gnbc_pkg::COST_MAX;
        end else begin
            n_cost = total[gnbc_pkg::COST_W-1:0];
        end
    end

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cost  <= n_cost;
            r_error <= i_snap.err;
        end
    end

    assign o_valid = r_valid;
    assign o_cost  = r_cost;
    assign o_error = r_error;

endmodule

// ===== test/grid_net_bbox_cost_tb.sv =====
// self-checking testbench for the grid net bounding box cost block
`timescale 1ns / 1ps

module grid_net_bbox_cost_tb;

    // run control
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 40;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [gnbc_pkg::COST_W-1:0] cost;
        logic                        error;
    } t_net_result;

    typedef enum logic {ROW_CELL, ROW_WIDTH} t_row_kind;

    // one directed row: a cell transaction or a row width write
    typedef struct packed {
        t_row_kind                    kind;
        logic [gnbc_pkg::COUNT_W-1:0] value;
        logic                         last;
        logic                         typed;
        logic [gnbc_pkg::COST_W-1:0]  cost;
        logic                         error;
    } t_stim_row;

    localparam int DIRECTED_ROWS = 24;
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        // empty net straight after reset
        '{ROW_CELL,  16'h0000, 1'b1, 1'b1, 11'd0, 1'b0},
        // largest positive count on a single cell
        '{ROW_CELL,  16'h7FFF, 1'b1, 1'b1, 11'd2, 1'b0},
        // negative count only: empty with error
        '{ROW_CELL,  16'hFFFF, 1'b1, 1'b1, 11'd0, 1'b1},
        // most negative count, then an occupied cell in column two
        '{ROW_CELL,  16'h8000, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_CELL,  16'h0001, 1'b1, 1'b1, 11'd2, 1'b1},
        // two by two box over a wrap at the reset row width
        '{ROW_CELL,  16'h0001, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_CELL,  16'h0000, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_CELL,  16'h0000, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_CELL,  16'h0000, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_CELL,  16'h0000, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_CELL,  16'h0002, 1'b1, 1'b1, 11'd6, 1'b0},
        // row width narrowed while the column counter sits past it
        '{ROW_CELL,  16'h0003, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_CELL,  16'h0000, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_CELL,  16'h0000, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_WIDTH, 16'd2,    1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_CELL,  16'h0001, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_CELL,  16'h0001, 1'b1, 1'b0, 11'd0, 1'b0},
        // zero row width behaves as one column
        '{ROW_WIDTH, 16'd0,    1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_CELL,  16'h0001, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_CELL,  16'h0000, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_CELL,  16'h0001, 1'b1, 1'b0, 11'd0, 1'b0},
        // oversized row width clamps to the column limit
        '{ROW_WIDTH, 16'd127,  1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_CELL,  16'h0000, 1'b0, 1'b0, 11'd0, 1'b0},
        '{ROW_CELL,  16'h0040, 1'b1, 1'b0, 11'd0, 1'b0}
    };

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic [gnbc_pkg::COUNT_W-1:0] i_part_count;
    logic                         i_last;
    logic                         o_valid;
    logic                         i_stall;
    logic [gnbc_pkg::COST_W-1:0]  o_cost;
    logic                         o_error;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [gnbc_pkg::COL_W-1:0]   i_cfg_data;

    // expected net results in arrival order
    t_net_result pending_costs [$];

    int mismatches    = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 24;
    int hold_pct      = 76;

    // net tracker state kept alongside the block
    logic [gnbc_pkg::COL_W-1:0] width_setting = 7'd4;
    logic [gnbc_pkg::COL_W-1:0] at_col;
    logic [gnbc_pkg::ROW_W-1:0] at_row;
    logic [gnbc_pkg::ROW_W-1:0] low_row;
    logic [gnbc_pkg::ROW_W-1:0] high_row;
    logic [gnbc_pkg::COL_W-1:0] low_col;
    logic [gnbc_pkg::COL_W-1:0] high_col;
    logic [gnbc_pkg::CNT_W-1:0] occupied;
    logic [gnbc_pkg::CNT_W-1:0] cells_taken;
    logic                       saw_error;

    grid_net_bbox_cost i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_part_count (i_part_count),
        .i_last       (i_last),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_cost       (o_cost),
        .o_error      (o_error),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // tracker back to an empty net
    function automatic void clear_net();
        at_col      = gnbc_pkg::COL_W'(1);
        at_row      = gnbc_pkg::ROW_W'(1);
        low_row     = '1;
        high_row    = '0;
        low_col     = '1;
        high_col    = '0;
        occupied    = '0;
        cells_taken = '0;
        saw_error   = 1'b0;
    endfunction

    // advance the tracker by one cell and work out the cost on the last one
    task automatic track_cell(input logic [gnbc_pkg::COUNT_W-1:0] count, input logic last,
                              output logic produced, output t_net_result res);
        logic negative;
        logic positive;
        int   span;
        int   total;
        negative = count[gnbc_pkg::COUNT_W-1];
        positive = !negative && (count != '0);
        if (width_setting == 0)
            span = 1;
        else if (width_setting > gnbc_pkg::MAX_COLUMNS)
            span = gnbc_pkg::MAX_COLUMNS;
        else
            span = int'(width_setting);
        if (cells_taken >= gnbc_pkg::MAX_PARTS) begin
            saw_error = 1'b1;
        end else begin
            if (negative)
                saw_error = 1'b1;
            if (positive) begin
                occupied++;
                if (at_row < low_row) low_row = at_row;
                if (at_row > high_row) high_row = at_row;
                if (at_col < low_col) low_col = at_col;
                if (at_col > high_col) high_col = at_col;
            end
            cells_taken++;
            if (int'(at_col) >= span) begin
                at_col = gnbc_pkg::COL_W'(1);
                at_row++;
            end else begin
                at_col++;
            end
        end
        produced = last;
        res      = '0;
        if (last) begin
            total = 0;
            if (occupied != 0) begin
                total = (int'(high_row) - int'(low_row) + 1)
                      * (int'(high_col) - int'(low_col) + 1) + int'(occupied);
                if (total > int'(gnbc_pkg::COST_MAX))
                    total = int'(gnbc_pkg::COST_MAX);
            end
            res.cost  = total[gnbc_pkg::COST_W-1:0];
            res.error = saw_error;
            clear_net();
        end
    endtask

    // random pin count, mostly empty or small, sometimes any 16-bit value
    function automatic logic [gnbc_pkg::COUNT_W-1:0] random_count();
        int                           pick;
        logic [gnbc_pkg::COUNT_W-1:0] v;
        pick = $urandom_range(19);
        v    = gnbc_pkg::COUNT_W'($urandom);
        if (pick < 10)
            return '0;
        else if (pick < 16)
            return gnbc_pkg::COUNT_W'($urandom_range(1, 9));
        else if (pick < 18)
            return v;
        else if (pick < 19)
            return {1'b1, v[gnbc_pkg::COUNT_W-2:0]};
        else
            return ($urandom_range(1) == 0) ? 16'h7FFF : 16'h8000;
    endfunction

    // one cell transaction, with a random gap in front of it
    task automatic send_cell(input logic [gnbc_pkg::COUNT_W-1:0] count, input logic last,
                             input logic typed, input t_net_result typed_res);
        logic        produced;
        t_net_result res;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_part_count <= count;
        i_last       <= last;
        do @(posedge i_clk); while (o_stall);
        track_cell(count, last, produced, res);
        if (produced)
            pending_costs.push_back(typed ? typed_res : res);
    endtask

    // write the row width once the block has gone quiet
    task automatic set_width(input logic [gnbc_pkg::COL_W-1:0] value);
        i_valid <= 1'b0;
        while (pending_costs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        width_setting = value;
    endtask

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_stall <= (hold_pct != 0) && ($urandom_range(99) < hold_pct);
    end

    // result checking against the oldest expectation
    always @(posedge i_clk) begin
        t_net_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_costs.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("net result with none expected: cost %0d error %0b",
                             o_cost, o_error);
            end else begin
                want = pending_costs.pop_front();
                if (o_cost !== want.cost || o_error !== want.error) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mismatch: want cost %0d error %0b, got cost %0d error %0b",
                                 want.cost, want.error, o_cost, o_error);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("grid_net_bbox_cost test failed");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_stim_row                  row;
        t_net_result                typed_res;
        logic [gnbc_pkg::COL_W-1:0] plan_width;
        int                         sent;
        int                         len;
        int                         k;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_part_count = '0;
        i_last       = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        clear_net();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (int n = 0; n < DIRECTED_ROWS; n++) begin
            row = DIRECTED[n];
            if (row.kind == ROW_WIDTH) begin
                set_width(row.value[gnbc_pkg::COL_W-1:0]);
            end else begin
                typed_res.cost  = row.cost;
                typed_res.error = row.error;
                send_cell(row.value, row.last, row.typed, typed_res);
            end
        end

        // random nets over three idling modes and several row widths
        for (int mode = 0; mode < 3; mode++) begin
            if (mode == 1) begin
                send_idle_pct = 76;
                hold_pct      = 24;
            end else if (mode == 2) begin
                send_idle_pct = 0;
                hold_pct      = 0;
            end
            for (int phase = 0; phase < 4; phase++) begin
                k = mode * 4 + phase;
                case (k)
                    0: begin
                        plan_width = 7'd1;
                    end
                    1: begin
                        plan_width = 7'd64;
                    end
                    2: begin
                        plan_width = 7'd0;
                    end
                    3: begin
                        plan_width = 7'd127;
                    end
                    default: begin
                        plan_width = gnbc_pkg::COL_W'($urandom_range(127));
                    end
                endcase
                set_width(plan_width);
                // one sparse net running past the grid store
                if (k == 5) begin
                    len = $urandom_range(513, 524);
                    for (int c = 0; c < len; c++)
                        send_cell(($urandom_range(15) == 0) ? random_count() : '0,
                                  c == len - 1, 1'b0, '0);
                end
                sent = 0;
                while (sent < PHASE_ITEMS) begin
                    len = ($urandom_range(3) == 0) ? $urandom_range(1, 3)
                                                   : $urandom_range(1, 24);
                    for (int c = 0; c < len; c++)
                        send_cell(random_count(), c == len - 1, 1'b0, '0);
                    sent += len;
                end
                // sometimes leave a net open across the next width change
                if (k != 11 && $urandom_range(2) == 0) begin
                    len = $urandom_range(1, 5);
                    for (int c = 0; c < len; c++)
                        send_cell(random_count(), 1'b0, 1'b0, '0);
                end
            end
        end

        // drain and report
        i_valid <= 1'b0;
        while (pending_costs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("grid_net_bbox_cost test passed");
        else
            $display("grid_net_bbox_cost test failed");
        $finish;
    end

endmodule
